// File: hdl/mean_reverting_rate_generator_assert.svh
// ----------------------------------------------------------------------------
// mean reverting rate generator assertion macros
// shared property shapes for the port checker
// ----------------------------------------------------------------------------
`ifndef MEAN_REVERTING_RATE_GENERATOR_ASSERT_SVH
`define MEAN_REVERTING_RATE_GENERATOR_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define MRRG_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define MRRG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/mrrg_pkg.sv
// ----------------------------------------------------------------------------
// mrrg_pkg
// widths, constants and shared types of the mean reverting rate generator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mrrg_pkg;

    // port and datapath widths
    localparam int unsigned CFG_DATA_W  = 64;
    localparam int unsigned CFG_ADDR_W  = 3;
    localparam int unsigned RATE_W      = 41;
    localparam int unsigned DIFF_W      = 42;
    localparam int unsigned SUM_W       = 44;
    localparam int unsigned K_W         = 41;
    localparam int unsigned MAG_W       = 53;
    localparam int unsigned ACC_W       = 96;
    localparam int unsigned PUB_W       = 21;
    localparam int unsigned DAY_W       = 16;
    localparam int unsigned IN_TDATA_W  = 16;
    localparam int unsigned OUT_TDATA_W = 40;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_INITIAL_STATE = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_MEAN_LEVEL    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_REVERSION     = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_STEP_SCALE    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_RATE_FLOOR    = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_RATE_CEILING  = 3'd5;

    // register reset values
    localparam logic signed [RATE_W-1:0] FLOOR_RST   = -41'sd1000000000000;
    localparam logic signed [RATE_W-1:0] CEILING_RST = 41'sd1000000000000;

    // splitmix64 constants
    localparam logic [63:0] GOLDEN_INC = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] MIX_MUL_A  = 64'hBF58476D1CE4E5B9;
    localparam logic [63:0] MIX_MUL_B  = 64'h94D049BB133111EB;

    // sqrt(3) in q30, sample offset 2^52
    localparam logic [31:0]      SQRT3_Q30 = 32'd1859775393;
    localparam logic [MAG_W-1:0] HALF_SPAN = 53'h10000000000000;

    // publish divide by 10^6: reciprocal floor(2^41 / 10^6), one correction step
    localparam logic [31:0]       PUB_DIV    = 32'd1000000;
    localparam logic [31:0]       PUB_RECIP  = 32'd2199023;
    localparam logic [RATE_W-1:0] PUB_HALF   = 41'd500000;
    localparam logic [RATE_W-1:0] PUB_DIV_W  = 41'd1000000;
    localparam logic [PUB_W-1:0]  PUB_POS_MAX = 21'h0FFFFF;
    localparam logic [PUB_W-1:0]  PUB_NEG_MAX = 21'h100000;

    // rounding offsets applied to the accumulator
    localparam logic [ACC_W-1:0] RND_Q30 = 96'h1 << 29;
    localparam logic [ACC_W-1:0] RND_Q32 = 96'h1 << 31;
    localparam logic [ACC_W-1:0] RND_Q52 = 96'h1 << 51;

    // partial product placement in the accumulator
    typedef enum logic [1:0] {
        SH_0  = 2'd0,
        SH_32 = 2'd1,
        SH_64 = 2'd2
    } t_mac_sh;

    // one multiply-accumulate issue
    typedef struct packed {
        logic    valid;
        logic    first;
        t_mac_sh sh;
    } t_mac_ctl;

endpackage

// File: hdl/mrrg_mac.sv
// ----------------------------------------------------------------------------
// mrrg_mac
// shared 32x32 multiplier with a shifted 96-bit accumulator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mrrg_mac (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  mrrg_pkg::t_mac_ctl          i_ctl,
    input  logic [31:0]                 i_op_a,
    input  logic [31:0]                 i_op_b,
    output logic [mrrg_pkg::ACC_W-1:0]  o_acc
);

    mrrg_pkg::t_mac_ctl           r_ctl;
    logic [63:0]                  r_prod;
    logic [63:0]                  w_prod;
    logic [mrrg_pkg::ACC_W-1:0]   r_acc;
    logic [mrrg_pkg::ACC_W-1:0]   n_acc;
    logic [mrrg_pkg::ACC_W-1:0]   w_term;

    // product stage
    assign w_prod = {32'd0, i_op_a} * {32'd0, i_op_b};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
    end

    // place the product at its limb offset
    always_comb begin
        case (r_ctl.sh)
            mrrg_pkg::SH_0:  w_term = {32'd0, r_prod};
            mrrg_pkg::SH_32: w_term = {r_prod, 32'd0};
            mrrg_pkg::SH_64: w_term = {r_prod[31:0], 64'd0};
            default:         w_term = '0;
        endcase
    end

    // accumulate, first partial product starts a new sum
    assign n_acc = (r_ctl.first ? '0 : r_acc) + w_term;

    always_ff @(posedge i_clk) begin
        if (r_ctl.valid) begin
            r_acc <= n_acc;
        end
    end

    assign o_acc = r_acc;

endmodule

// File: hdl/mean_reverting_rate_generator.sv
// ----------------------------------------------------------------------------
// mean_reverting_rate_generator
// splitmix64 driven mean reverting daily rate, published in 1e-6 units
// ----------------------------------------------------------------------------
// a business day runs MIX1, MIX2, SCALE, STEP, PULL, CLAMP, ROUND, DIV, BACK, DONE
// and the input stays closed until it is done; a skipped day is taken in idle
// the sequence is set by the shared 32x32 multiplier: 17 partial products per day
// the input is taken again while a result still waits on the output register
// reset: synchronous active low, registers to reset values, seed 0, rate 0
`timescale 1ns / 1ps

module mean_reverting_rate_generator (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [mrrg_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // [15:0] day_offset
    input  logic                                s_axis_tlast,  // last_day
    input  logic                                s_axis_tuser,  // business_day
    // output stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [mrrg_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,  // [20:0] published_rate,
                                                               // [36:21] result_day,
                                                               // [39:37] zero
    // configuration writes
    input  logic                                i_cfg_wr_en,
    input  logic [mrrg_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [mrrg_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);

    typedef enum logic [10:0] {
        ST_IDLE  = 11'b00000000001,
        ST_MIX1  = 11'b00000000010,
        ST_MIX2  = 11'b00000000100,
        ST_SCALE = 11'b00000001000,
        ST_STEP  = 11'b00000010000,
        ST_PULL  = 11'b00000100000,
        ST_CLAMP = 11'b00001000000,
        ST_ROUND = 11'b00010000000,
        ST_DIV   = 11'b00100000000,
        ST_BACK  = 11'b01000000000,
        ST_DONE  = 11'b10000000000
    } t_state;

    // configuration registers
    logic [63:0]                         r_cfg_init;
    logic signed [mrrg_pkg::RATE_W-1:0]  r_cfg_level;
    logic [31:0]                         r_cfg_rev;
    logic [39:0]                         r_cfg_step;
    logic signed [mrrg_pkg::RATE_W-1:0]  r_cfg_floor;
    logic signed [mrrg_pkg::RATE_W-1:0]  r_cfg_ceil;

    // walk state
    logic [63:0]                         r_gen;
    logic signed [mrrg_pkg::RATE_W-1:0]  r_rate;

    // sequencer
    t_state                              r_state;
    t_state                              n_state;
    logic [2:0]                          r_cnt;
    logic [2:0]                          n_cnt;
    logic [2:0]                          w_nprod;
    logic                                w_issue;
    logic                                w_fin;

    // working registers
    logic [63:0]                         r_x;
    logic [mrrg_pkg::K_W-1:0]            r_k;
    logic [mrrg_pkg::MAG_W-1:0]          r_dmag;
    logic                                r_dneg;
    logic [mrrg_pkg::DIFF_W-1:0]         r_dfmag;
    logic                                r_dfneg;
    logic signed [mrrg_pkg::SUM_W-1:0]   r_sum;
    logic signed [mrrg_pkg::RATE_W-1:0]  r_res;
    logic                                r_rneg;
    logic [mrrg_pkg::PUB_W-1:0]          r_q;
    logic [mrrg_pkg::DAY_W-1:0]          r_day;
    logic                                r_last;

    // output register
    logic                                r_out_valid;
    logic                                n_out_valid;
    logic [mrrg_pkg::PUB_W-1:0]          r_out_rate;
    logic [mrrg_pkg::DAY_W-1:0]          r_out_day;

    // shared multiplier port
    mrrg_pkg::t_mac_ctl                  w_mac_ctl;
    mrrg_pkg::t_mac_sh                   w_sh;
    logic [31:0]                         w_op_a;
    logic [31:0]                         w_op_b;
    logic [mrrg_pkg::ACC_W-1:0]          w_acc;

    // combinational helpers
    logic                                w_in_acc;
    logic                                w_out_free;
    logic [63:0]                         w_gen_inc;
    logic signed [mrrg_pkg::DIFF_W-1:0]  w_diff;
    logic [63:0]                         w_mix;
    logic [63:0]                         w_draw;
    logic [mrrg_pkg::MAG_W-1:0]          w_t;
    logic [mrrg_pkg::ACC_W-1:0]          w_k_rnd;
    logic [mrrg_pkg::ACC_W-1:0]          w_step_rnd;
    logic [mrrg_pkg::ACC_W-1:0]          w_pull_rnd;
    logic signed [mrrg_pkg::SUM_W-1:0]   w_step_term;
    logic signed [mrrg_pkg::SUM_W-1:0]   w_pull_term;
    logic signed [mrrg_pkg::SUM_W-1:0]   w_floor_ext;
    logic signed [mrrg_pkg::SUM_W-1:0]   w_ceil_ext;
    logic signed [mrrg_pkg::SUM_W-1:0]   w_clamp_lo;
    logic signed [mrrg_pkg::SUM_W-1:0]   w_clamp_hi;
    logic [mrrg_pkg::RATE_W-1:0]         w_rnd_x;
    logic [mrrg_pkg::RATE_W-1:0]         w_rem;
    logic [mrrg_pkg::PUB_W-1:0]          w_pub;

    // handshakes
    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_out_valid || m_axis_tready;

    // partial products per multiply phase
    always_comb begin
        unique case (r_state) inside
            ST_MIX1, ST_MIX2:         w_nprod = 3'd3;
            ST_SCALE, ST_PULL, ST_DIV: w_nprod = 3'd2;
            ST_STEP:                  w_nprod = 3'd4;
            ST_BACK:                  w_nprod = 3'd1;
            default:                  w_nprod = 3'd0;
        endcase
    end

    assign w_issue = (w_nprod != 3'd0) && (r_cnt < w_nprod);
    assign w_fin   = (w_nprod != 3'd0) && (r_cnt == 3'(w_nprod + 3'd1));

    // operand selection: limb products with their accumulator offset
    always_comb begin
        w_op_a = '0;
        w_op_b = '0;
        w_sh   = mrrg_pkg::SH_0;
        case (r_state)
            ST_MIX1, ST_MIX2: begin
                w_op_b = (r_state == ST_MIX1) ? mrrg_pkg::MIX_MUL_A[31:0]
                                              : mrrg_pkg::MIX_MUL_B[31:0];
                case (r_cnt)
                    3'd0: w_op_a = r_x[31:0];
                    3'd1: begin
                        w_op_a = r_x[31:0];
                        w_op_b = (r_state == ST_MIX1) ? mrrg_pkg::MIX_MUL_A[63:32]
                                                      : mrrg_pkg::MIX_MUL_B[63:32];
                        w_sh   = mrrg_pkg::SH_32;
                    end
                    default: begin
                        w_op_a = r_x[63:32];
                        w_sh   = mrrg_pkg::SH_32;
                    end
                endcase
            end
            ST_SCALE: begin
                w_op_b = mrrg_pkg::SQRT3_Q30;
                if (r_cnt == 3'd0) begin
                    w_op_a = r_cfg_step[31:0];
                end else begin
                    w_op_a = {24'd0, r_cfg_step[39:32]};
                    w_sh   = mrrg_pkg::SH_32;
                end
            end
            ST_STEP: begin
                case (r_cnt)
                    3'd0: begin
                        w_op_a = r_k[31:0];
                        w_op_b = r_dmag[31:0];
                    end
                    3'd1: begin
                        w_op_a = r_k[31:0];
                        w_op_b = {11'd0, r_dmag[52:32]};
                        w_sh   = mrrg_pkg::SH_32;
                    end
                    3'd2: begin
                        w_op_a = {23'd0, r_k[40:32]};
                        w_op_b = r_dmag[31:0];
                        w_sh   = mrrg_pkg::SH_32;
                    end
                    default: begin
                        w_op_a = {23'd0, r_k[40:32]};
                        w_op_b = {11'd0, r_dmag[52:32]};
                        w_sh   = mrrg_pkg::SH_64;
                    end
                endcase
            end
            ST_PULL: begin
                w_op_a = r_cfg_rev;
                if (r_cnt == 3'd0) begin
                    w_op_b = r_dfmag[31:0];
                end else begin
                    w_op_b = {22'd0, r_dfmag[41:32]};
                    w_sh   = mrrg_pkg::SH_32;
                end
            end
            ST_DIV: begin
                w_op_b = mrrg_pkg::PUB_RECIP;
                if (r_cnt == 3'd0) begin
                    w_op_a = r_x[31:0];
                end else begin
                    w_op_a = {23'd0, r_x[40:32]};
                    w_sh   = mrrg_pkg::SH_32;
                end
            end
            ST_BACK: begin
                w_op_a = {11'd0, r_q};
                w_op_b = mrrg_pkg::PUB_DIV;
            end
            default: begin
                w_op_a = '0;
            end
        endcase
    end

    assign w_mac_ctl.valid = w_issue;
    assign w_mac_ctl.first = (r_cnt == 3'd0);
    assign w_mac_ctl.sh    = w_sh;

    mrrg_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_mac_ctl),
        .i_op_a  (w_op_a),
        .i_op_b  (w_op_b),
        .o_acc   (w_acc)
    );

    // generator advance and distance to the level
    assign w_gen_inc = r_gen + mrrg_pkg::GOLDEN_INC;
    assign w_diff    = {r_cfg_level[40], r_cfg_level} - {r_rate[40], r_rate};

    // mixing finish values and the centered sample
    assign w_mix  = w_acc[63:0];
    assign w_draw = w_mix ^ (w_mix >> 31);
    assign w_t    = w_draw[63:11];

    // rounded scaled terms
    assign w_k_rnd     = w_acc + mrrg_pkg::RND_Q30;
    assign w_step_rnd  = w_acc + mrrg_pkg::RND_Q52;
    assign w_pull_rnd  = w_acc + mrrg_pkg::RND_Q32;
    assign w_step_term = {2'b00, w_step_rnd[93:52]};
    assign w_pull_term = {2'b00, w_pull_rnd[73:32]};

    // floor first, then ceiling
    assign w_floor_ext = {{3{r_cfg_floor[40]}}, r_cfg_floor};
    assign w_ceil_ext  = {{3{r_cfg_ceil[40]}}, r_cfg_ceil};
    assign w_clamp_lo  = (r_sum < w_floor_ext) ? w_floor_ext : r_sum;
    assign w_clamp_hi  = (w_clamp_lo > w_ceil_ext) ? w_ceil_ext : w_clamp_lo;

    // magnitude plus half a publish unit
    assign w_rnd_x = r_res[40] ? (mrrg_pkg::PUB_HALF - r_res) : (r_res + mrrg_pkg::PUB_HALF);

    // remainder of the reciprocal quotient
    assign w_rem = r_x[40:0] - w_acc[40:0];

    // saturate and sign the published value
    always_comb begin
        if (r_rneg) begin
            w_pub = (r_q > mrrg_pkg::PUB_NEG_MAX) ? mrrg_pkg::PUB_NEG_MAX : (~r_q + 21'd1);
        end else begin
            w_pub = (r_q > mrrg_pkg::PUB_POS_MAX) ? mrrg_pkg::PUB_POS_MAX : r_q;
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        if (w_nprod != 3'd0) begin
            n_cnt = 3'(r_cnt + 3'd1);
        end
        unique case (r_state)
            ST_IDLE: begin
                n_cnt = '0;
                if (w_in_acc && s_axis_tuser) begin
                    n_state = ST_MIX1;
                end
            end
            ST_MIX1:  if (w_fin) begin n_state = ST_MIX2;  n_cnt = '0; end
            ST_MIX2:  if (w_fin) begin n_state = ST_SCALE; n_cnt = '0; end
            ST_SCALE: if (w_fin) begin n_state = ST_STEP;  n_cnt = '0; end
            ST_STEP:  if (w_fin) begin n_state = ST_PULL;  n_cnt = '0; end
            ST_PULL:  if (w_fin) begin n_state = ST_CLAMP; n_cnt = '0; end
            ST_CLAMP: n_state = ST_ROUND;
            ST_ROUND: begin
                n_state = ST_DIV;
                n_cnt   = '0;
            end
            ST_DIV:   if (w_fin) begin n_state = ST_BACK;  n_cnt = '0; end
            ST_BACK:  if (w_fin) begin n_state = ST_DONE;  n_cnt = '0; end
            ST_DONE:  if (w_out_free) begin n_state = ST_IDLE; end
            default: begin
                n_state = ST_IDLE;
                n_cnt   = '0;
            end
        endcase
    end

    // output register valid
    always_comb begin
        n_out_valid = r_out_valid;
        if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end
        if ((r_state == ST_DONE) && w_out_free) begin
            n_out_valid = 1'b1;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // configuration registers and the walk state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_init  <= '0;
            r_cfg_level <= '0;
            r_cfg_rev   <= '0;
            r_cfg_step  <= '0;
            r_cfg_floor <= mrrg_pkg::FLOOR_RST;
            r_cfg_ceil  <= mrrg_pkg::CEILING_RST;
            r_gen       <= '0;
            r_rate      <= '0;
        end else begin
            // business day: advance the generator; skipped day: only a final day reload
            if (w_in_acc && s_axis_tuser) begin
                r_gen <= w_gen_inc;
            end else if (w_in_acc && s_axis_tlast) begin
                r_gen  <= r_cfg_init;
                r_rate <= r_cfg_level;
            end
            // day finished: commit the rate or reload after the final day
            if ((r_state == ST_DONE) && w_out_free) begin
                if (r_last) begin
                    r_gen  <= r_cfg_init;
                    r_rate <= r_cfg_level;
                end else begin
                    r_rate <= r_res;
                end
            end
            // register writes are to be taken only while idle; the block itself does not enforce it
            if (i_cfg_wr_en) begin
                unique case (i_cfg_addr)
                    mrrg_pkg::REG_INITIAL_STATE: begin
                        r_cfg_init <= i_cfg_wdata;
                        r_gen      <= i_cfg_wdata;
                    end
                    mrrg_pkg::REG_MEAN_LEVEL: begin
                        r_cfg_level <= i_cfg_wdata[40:0];
                        r_rate      <= i_cfg_wdata[40:0];
                    end
                    mrrg_pkg::REG_REVERSION:    r_cfg_rev   <= i_cfg_wdata[31:0];
                    mrrg_pkg::REG_STEP_SCALE:   r_cfg_step  <= i_cfg_wdata[39:0];
                    mrrg_pkg::REG_RATE_FLOOR:   r_cfg_floor <= i_cfg_wdata[40:0];
                    mrrg_pkg::REG_RATE_CEILING: r_cfg_ceil  <= i_cfg_wdata[40:0];
                    default: begin
                        r_cfg_rev <= r_cfg_rev;
                    end
                endcase
            end
        end
    end

    // working datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    r_day   <= s_axis_tdata;
                    r_last  <= s_axis_tlast;
                    r_x     <= w_gen_inc ^ (w_gen_inc >> 30);
                    r_sum   <= {{3{r_rate[40]}}, r_rate};
                    r_dfneg <= w_diff[41];
                    r_dfmag <= w_diff[41] ? (~w_diff + 42'd1) : w_diff;
                end
            end
            ST_MIX1: begin
                if (w_fin) begin
                    r_x <= w_mix ^ (w_mix >> 27);
                end
            end
            ST_MIX2: begin
                if (w_fin) begin
                    r_dneg <= !w_t[52];
                    r_dmag <= w_t[52] ? {1'b0, w_t[51:0]}
                                      : (mrrg_pkg::HALF_SPAN - {1'b0, w_t[51:0]});
                end
            end
            ST_SCALE: begin
                if (w_fin) begin
                    r_k <= w_k_rnd[70:30];
                end
            end
            ST_STEP: begin
                if (w_fin) begin
                    r_sum <= r_dneg ? (r_sum - w_step_term) : (r_sum + w_step_term);
                end
            end
            ST_PULL: begin
                if (w_fin) begin
                    r_sum <= r_dfneg ? (r_sum - w_pull_term) : (r_sum + w_pull_term);
                end
            end
            ST_CLAMP: begin
                r_res <= w_clamp_hi[40:0];
            end
            ST_ROUND: begin
                r_rneg <= r_res[40];
                r_x    <= {23'd0, w_rnd_x};
            end
            ST_DIV: begin
                if (w_fin) begin
                    r_q <= w_acc[61:41];
                end
            end
            ST_BACK: begin
                if (w_fin && (w_rem >= mrrg_pkg::PUB_DIV_W)) begin
                    r_q <= 21'(r_q + 21'd1);
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    r_out_rate <= w_pub;
                    r_out_day  <= r_day;
                end
            end
            default: begin
                r_q <= r_q;
            end
        endcase
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out_day, r_out_rate};

endmodule

// File: hdl/mrrg_checker.sv
// ----------------------------------------------------------------------------
// mrrg_checker
// port level checks of the mean reverting rate generator, bound to the top
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "mean_reverting_rate_generator_assert.svh"

module mrrg_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic                              s_axis_tuser,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [mrrg_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

    // a stalled result holds its value
    `MRRG_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

    // a business day keeps the input closed while it is worked on
    `MRRG_ASSERT_NEXT(a_busy_after_day, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready && s_axis_tuser, !s_axis_tready, "input open during a business day")

    // a skipped day gives no result
    `MRRG_ASSERT_NEXT(a_skip_silent, i_clk, i_rst_n, !m_axis_tvalid && s_axis_tvalid && s_axis_tready && !s_axis_tuser, !m_axis_tvalid, "result after a skipped day")

    // a new result appears only as the block returns to idle
    `MRRG_ASSERT_SAME(a_result_idle, i_clk, i_rst_n, $rose(m_axis_tvalid), s_axis_tready, "result while still busy")

endmodule

bind mean_reverting_rate_generator mrrg_checker u_mrrg_checker (.*);

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// mean_reverting_rate_generator testbench
// drives calendar days through the input stream and checks every published
// rate against an in-bench model of the splitmix64 driven random walk;
// directed corner settings first, then random series under random stalls
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// expected published rates, with the running model of the walk
class fixing_scoreboard;

    localparam logic [63:0]   WEYL_STEP  = 64'h9E3779B97F4A7C15;
    localparam logic [63:0]   MIX_A      = 64'hBF58476D1CE4E5B9;
    localparam logic [63:0]   MIX_B      = 64'h94D049BB133111EB;
    localparam logic [63:0]   ROOT3_Q30  = 64'd1859775393;
    localparam longint        SAMPLE_MID = 64'sd4503599627370496;
    localparam logic [63:0]   MICRO      = 64'd1000000;
    localparam longint        PUB_TOP    = 64'sd1048575;
    localparam longint        PUB_BOTTOM = -64'sd1048576;
    localparam int            PRINT_CAP  = 40;

    typedef struct packed {
        logic [20:0] rate;
        logic [15:0] day;
    } fixing_t;

    // register copies
    logic [63:0] seed_reg;
    longint      level_reg;
    logic [31:0] pull_reg;
    logic [39:0] step_reg;
    longint      floor_reg;
    longint      ceiling_reg;

    // walk state
    logic [63:0] gen_state;
    longint      rate_now;

    fixing_t expected_fixings[$];
    int      errors;
    int      checked;

    function new();
        seed_reg    = '0;
        level_reg   = 0;
        pull_reg    = '0;
        step_reg    = '0;
        floor_reg   = -64'sd1000000000000;
        ceiling_reg = 64'sd1000000000000;
        gen_state   = '0;
        rate_now    = 0;
        errors      = 0;
        checked     = 0;
    endfunction

    function int pending();
        return expected_fixings.size();
    endfunction

    function longint sext41(logic [63:0] value);
        logic signed [40:0] narrow;
        narrow = value[40:0];
        return narrow;
    endfunction

    // round(a * b / 2^sh), half up
    function logic [63:0] scaled_product(logic [63:0] a, logic [63:0] b, int unsigned sh);
        logic [127:0] prod;
        prod = {64'd0, a} * {64'd0, b};
        prod = prod + (128'd1 << (sh - 1));
        prod = prod >> sh;
        return prod[63:0];
    endfunction

    // magnitude scaled, sign put back: rounding half away from zero
    function longint signed_scaled(longint v, logic [63:0] f, int unsigned sh);
        logic [63:0] mag;
        logic [63:0] res;
        mag = (v < 0) ? 64'(-v) : 64'(v);
        res = scaled_product(mag, f, sh);
        return (v < 0) ? -longint'(res) : longint'(res);
    endfunction

    function logic [63:0] next_draw();
        logic [63:0] z;
        gen_state = gen_state + WEYL_STEP;
        z = gen_state;
        z = (z ^ (z >> 30)) * MIX_A;
        z = (z ^ (z >> 27)) * MIX_B;
        return z ^ (z >> 31);
    endfunction

    function void write_reg(logic [2:0] addr, logic [63:0] value);
        case (addr)
            mrrg_pkg::REG_INITIAL_STATE: begin
                seed_reg  = value;
                gen_state = value;
            end
            mrrg_pkg::REG_MEAN_LEVEL: begin
                level_reg = sext41(value);
                rate_now  = level_reg;
            end
            mrrg_pkg::REG_REVERSION:    pull_reg    = value[31:0];
            mrrg_pkg::REG_STEP_SCALE:   step_reg    = value[39:0];
            mrrg_pkg::REG_RATE_FLOOR:   floor_reg   = sext41(value);
            mrrg_pkg::REG_RATE_CEILING: ceiling_reg = sext41(value);
            default: ;
        endcase
    endfunction

    // one accepted day: advance the walk and queue the fixing it publishes
    function void note_day(bit business, logic [15:0] day, bit last);
        longint      sample;
        longint      step_term;
        longint      pull_term;
        longint      next_rate;
        longint      pub;
        logic [63:0] k;
        logic [63:0] mag;
        fixing_t     fix;
        if (business) begin
            sample    = longint'(next_draw() >> 11) - SAMPLE_MID;
            k         = scaled_product({24'd0, step_reg}, ROOT3_Q30, 30);
            step_term = signed_scaled(sample, k, 52);
            pull_term = signed_scaled(level_reg - rate_now, {32'd0, pull_reg}, 32);
            next_rate = rate_now + pull_term + step_term;
            // floor first, ceiling wins when they cross
            if (next_rate < floor_reg)
                next_rate = floor_reg;
            if (next_rate > ceiling_reg)
                next_rate = ceiling_reg;
            rate_now = next_rate;
            mag = (next_rate < 0) ? 64'(-next_rate) : 64'(next_rate);
            mag = (mag + MICRO / 2) / MICRO;
            pub = (next_rate < 0) ? -longint'(mag) : longint'(mag);
            if (pub > PUB_TOP)
                pub = PUB_TOP;
            if (pub < PUB_BOTTOM)
                pub = PUB_BOTTOM;
            fix.rate = pub[20:0];
            fix.day  = day;
            expected_fixings.push_back(fix);
        end
        // end of series: walk restarts from the registers
        if (last) begin
            gen_state = seed_reg;
            rate_now  = level_reg;
        end
    endfunction

    task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        if (errors < PRINT_CAP)
            $display("ERROR %0t result %0d %s: got %0h expected %0h",
                     $time, checked, what, got, want);
        errors++;
    endtask

    task check_fixing(logic [39:0] tdata);
        fixing_t fix;
        if (expected_fixings.size() == 0) begin
            report_mismatch("unexpected transaction", tdata, '0);
        end else begin
            fix = expected_fixings.pop_front();
            if (tdata[20:0] !== fix.rate)
                report_mismatch("published_rate", tdata[20:0], fix.rate);
            if (tdata[36:21] !== fix.day)
                report_mismatch("result_day", tdata[36:21], fix.day);
            if (tdata[39:37] !== 3'd0)
                report_mismatch("padding", tdata[39:37], '0);
        end
        checked++;
    endtask

endclass

module testbench;

    import mrrg_pkg::*;

    localparam int     CLK_PERIOD   = 8;
    localparam int     RESET_CYCLES = 9;
    localparam int     QUIET_CYCLES = 48;
    localparam longint TIMEOUT_NS   = 64'd4000000;
    localparam longint RATE_LIM     = 64'sd1000000000000;
    localparam longint RATE_TOP41   = 64'sd1099511627775;
    localparam longint RATE_BOT41   = -64'sd1099511627776;
    localparam logic [39:0] STEP_TOP40 = 40'hFF_FFFF_FFFF;

    // indexes past the register file, writes there are dropped
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_B = 3'd7;

    typedef struct {
        logic [63:0] seed;
        longint      level;
        logic [31:0] pull;
        logic [39:0] step;
        longint      floor_rate;
        longint      ceiling_rate;
    } rate_settings_t;

    logic i_clk = 1'b0;
    logic i_rst_n;

    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;   // [15:0] day_offset
    logic                   s_axis_tlast;   // last_day
    logic                   s_axis_tuser;   // business_day
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;   // [20:0] published_rate, [36:21] result_day,
                                            // [39:37] zero
    logic                   i_cfg_wr_en;
    logic [CFG_ADDR_W-1:0]  i_cfg_addr;
    logic [CFG_DATA_W-1:0]  i_cfg_wdata;

    fixing_scoreboard sb;
    bit               idle_enable;

    mean_reverting_rate_generator u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // result side: random stall bursts while idling is on
    initial begin
        m_axis_tready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (idle_enable && $urandom_range(0, 9) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
        end
    end

    // check every output transaction
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_fixing(m_axis_tdata);
    end

    // hard stop
    initial begin
        #(TIMEOUT_NS);
        $display("mean_reverting_rate_generator: mismatch");
        $finish;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic longint rand_span(longint lim);
        logic [63:0] r;
        r = rand64() % 64'(2 * lim + 1);
        return longint'(r) - lim;
    endfunction

    function automatic int unsigned reg_width(logic [CFG_ADDR_W-1:0] addr);
        case (addr)
            REG_REVERSION:    return 32;
            REG_STEP_SCALE:   return 40;
            REG_MEAN_LEVEL,
            REG_RATE_FLOOR,
            REG_RATE_CEILING: return 41;
            default:          return 64;
        endcase
    endfunction

    // random register set; wide style goes out to the full 41-bit rates
    function automatic rate_settings_t pick_settings(bit wide);
        rate_settings_t s;
        longint         a;
        longint         b;
        s.seed = rand64();
        case ($urandom_range(0, 9))
            0:       s.seed = '0;
            1:       s.seed = '1;
            default: ;
        endcase
        case ($urandom_range(0, 5))
            0:       s.pull = '0;
            1:       s.pull = '1;
            default: s.pull = $urandom >> $urandom_range(0, 31);
        endcase
        if (wide) begin
            s.level        = $urandom_range(0, 1) ? RATE_TOP41 : RATE_BOT41;
            s.step         = $urandom_range(0, 1) ? STEP_TOP40 : 40'(rand64());
            s.floor_rate   = RATE_BOT41;
            s.ceiling_rate = RATE_TOP41;
        end else begin
            s.level = rand_span(RATE_LIM);
            case ($urandom_range(0, 5))
                0:       s.step = '0;
                1:       s.step = 40'(RATE_LIM);
                default: s.step = 40'((rand64() % 64'(RATE_LIM + 1)) >> $urandom_range(0, 30));
            endcase
            a = rand_span(RATE_LIM);
            b = rand_span(RATE_LIM);
            if ($urandom_range(0, 2) == 0) begin
                a = -RATE_LIM;
                b = RATE_LIM;
            end
            // mostly ordered, sometimes crossed
            if ((a > b) != ($urandom_range(0, 6) == 0)) begin
                s.floor_rate   = b;
                s.ceiling_rate = a;
            end else begin
                s.floor_rate   = a;
                s.ceiling_rate = b;
            end
        end
        return s;
    endfunction

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [63:0] value);
        logic [63:0]  bus_value;
        int unsigned  width;
        width     = reg_width(addr);
        bus_value = value;
        // junk above the register width must be dropped
        if (width < 64 && $urandom_range(0, 1))
            bus_value = (rand64() << width) | (value & ((64'd1 << width) - 1));
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= bus_value;
        @(posedge i_clk);
        sb.write_reg(addr, bus_value);
    endtask

    // writes the masked registers, starting at a random index
    task automatic load_settings(input rate_settings_t s, input logic [5:0] mask);
        int unsigned            start;
        logic [CFG_ADDR_W-1:0]  addr;
        logic [63:0]            value;
        start = $urandom_range(0, 5);
        for (int i = 0; i < 6; i++) begin
            addr = CFG_ADDR_W'((start + i) % 6);
            case (addr)
                REG_INITIAL_STATE: value = s.seed;
                REG_MEAN_LEVEL:    value = s.level;
                REG_REVERSION:     value = {32'd0, s.pull};
                REG_STEP_SCALE:    value = {24'd0, s.step};
                REG_RATE_FLOOR:    value = s.floor_rate;
                default:           value = s.ceiling_rate;
            endcase
            if (mask[addr])
                write_reg(addr, value);
        end
        if ($urandom_range(0, 3) == 0)
            write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, rand64());
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic send_day(input bit business, input logic [15:0] day, input bit last);
        if (idle_enable && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= day;
        s_axis_tlast  <= last;
        s_axis_tuser  <= business;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_day(business, day, last);
    endtask

    // sender holds off until every fixing is back and the block is quiet
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    // calendar series: consecutive days, weekends skipped, last day closes
    task automatic run_series(input int n_items);
        int           sent;
        int           len;
        logic [15:0]  day;
        bit           business;
        bit           last;
        sent = 0;
        while (sent < n_items) begin
            len = $urandom_range(1, 40);
            day = 16'($urandom);
            for (int i = 0; i < len && sent < n_items; i++) begin
                business = (day % 7) < 5;
                last     = (i == len - 1);
                if ($urandom_range(0, 9) == 0)
                    business = ~business;
                // noise: stray last flags and jumps in the day number
                if ($urandom_range(0, 19) == 0) begin
                    last = $urandom_range(0, 1);
                    day  = 16'($urandom);
                end
                send_day(business, day, last);
                day  = day + 16'd1;
                sent++;
            end
        end
    endtask

    initial begin
        rate_settings_t s;
        logic [5:0]     mask;

        sb            = new();
        idle_enable   = 1'b1;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        s_axis_tuser  = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_addr    = '0;
        i_cfg_wdata   = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: zero step and pull, both flags, day extremes
        send_day(1'b1, 16'h0000, 1'b0);
        send_day(1'b0, 16'hFFFF, 1'b0);
        send_day(1'b1, 16'hFFFF, 1'b0);
        send_day(1'b1, 16'h0005, 1'b1);
        send_day(1'b0, 16'h0006, 1'b1);
        send_day(1'b1, 16'h0007, 1'b0);
        settle();

        // widest rates, full pull and step: positive saturation of the output
        s.seed         = '1;
        s.level        = RATE_TOP41;
        s.pull         = '1;
        s.step         = STEP_TOP40;
        s.floor_rate   = RATE_BOT41;
        s.ceiling_rate = RATE_TOP41;
        load_settings(s, 6'b111111);
        write_reg(REG_SPARE_A, rand64());
        write_reg(REG_SPARE_B, rand64());
        i_cfg_wr_en <= 1'b0;
        for (int i = 0; i < 5; i++)
            send_day(1'b1, 16'(100 + i), i == 4);
        settle();

        // level at the bottom: negative saturation
        s.level = RATE_BOT41;
        mask    = '0;
        mask[REG_MEAN_LEVEL] = 1'b1;
        load_settings(s, mask);
        for (int i = 0; i < 4; i++)
            send_day(1'b1, 16'(200 + i), 1'b0);
        settle();

        // floor above ceiling: ceiling wins
        s.level        = 0;
        s.pull         = 32'h4000_0000;
        s.step         = 40'd50000000000;
        s.floor_rate   = 64'sd500000000000;
        s.ceiling_rate = -64'sd500000000000;
        load_settings(s, 6'b111111);
        send_day(1'b1, 16'd300, 1'b0);
        send_day(1'b1, 16'd301, 1'b0);
        send_day(1'b0, 16'd302, 1'b1);
        send_day(1'b1, 16'd303, 1'b0);
        settle();

        // random series; the last phase runs without idling
        for (int p = 0; p < 9; p++) begin
            s    = pick_settings(p == 2 || p == 6);
            mask = (p == 0) ? 6'b111111 : 6'($urandom);
            load_settings(s, mask);
            idle_enable = (p != 8);
            run_series((p == 8) ? 80 : 60);
            settle();
        end

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("mean_reverting_rate_generator: match");
        end else begin
            $display("mean_reverting_rate_generator: mismatch");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+hdl
hdl/mrrg_pkg.sv
hdl/mrrg_mac.sv
hdl/mean_reverting_rate_generator.sv
hdl/mrrg_checker.sv
test/testbench.sv
